// ----- rtl/mbrr_pkg.sv -----
package mbrr_pkg;

    localparam int STORE_DEPTH_DEF = 256;
    localparam int MAX_FRAME_DEF   = 256;

    localparam int BYTE_VALUES = 256;
    localparam int POS_W       = 9;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;

    typedef enum logic [1:0] {
        OP_RX_BYTE  = 2'd0,
        OP_TICK     = 2'd1,
        OP_STORE_WR = 2'd2,
        OP_TX_PULL  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_CRC   = 3'd1,
        ST_ADDR  = 3'd2,
        ST_FUNC  = 3'd3,
        ST_LEN   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        SEL_ADDR   = 3'd0,
        SEL_FUNC   = 3'd1,
        SEL_COUNT  = 3'd2,
        SEL_BODY   = 3'd3,
        SEL_CRC_LO = 3'd4,
        SEL_CRC_HI = 3'd5
    } t_sel;

    typedef enum logic {
        REG_SLAVE_ADDRESS = 1'b0,
        REG_IDLE_TICKS    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } t_store_wr;

    typedef struct packed {
        logic       re;
        logic [7:0] addr;
    } t_store_rd;

    typedef struct packed {
        logic       is_report;
        t_status    status;
        t_sel       sel;
        logic [7:0] count;
        logic       crc_init;
        logic       last;
    } t_tx_item;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/mbrr_in_if.sv -----
interface mbrr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [7:0] store_address;

    modport source (output valid, output operation, output data_byte, output store_address,
                    input ready);
    modport sink (input valid, input operation, input data_byte, input store_address,
                  output ready);
endinterface

// ----- rtl/mbrr_out_if.sv -----
interface mbrr_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic [2:0] frame_status;

    modport source (output valid, output kind, output tx_byte, output last_byte,
                    output frame_status, input ready);
    modport sink (input valid, input kind, input tx_byte, input last_byte,
                  input frame_status, output ready);
endinterface

// ----- rtl/mbrr_apb_cfg.sv -----
module mbrr_apb_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbrr_pkg::APB_AW-1:0] paddr,
    input  logic [mbrr_pkg::APB_DW-1:0] pwdata,
    output logic [mbrr_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [7:0]                  o_slave_address,
    output logic [7:0]                  o_idle_ticks
);

    logic [7:0]         r_slave_address;
    logic [7:0]         r_idle_ticks;
    mbrr_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign reg_idx = mbrr_pkg::t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= 8'd1;
            r_idle_ticks    <= 8'd3;
        end else if (wr_en) begin
            unique case (reg_idx)
                mbrr_pkg::REG_SLAVE_ADDRESS: r_slave_address <= pwdata[7:0];
                mbrr_pkg::REG_IDLE_TICKS:    r_idle_ticks    <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            mbrr_pkg::REG_SLAVE_ADDRESS: prdata = {24'h0, r_slave_address};
            mbrr_pkg::REG_IDLE_TICKS:    prdata = {24'h0, r_idle_ticks};
        endcase
    end

    assign o_slave_address = r_slave_address;
    assign o_idle_ticks    = r_idle_ticks;

endmodule

// ----- rtl/mbrr_reg_store.sv -----
module mbrr_reg_store #(
    parameter int STORE_DEPTH = mbrr_pkg::STORE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mbrr_pkg::t_store_wr  i_wr,
    input  mbrr_pkg::t_store_rd  i_rd,
    output logic [7:0]           o_rdata
);

    localparam int IW = $clog2(STORE_DEPTH);

    logic [IW-1:0]          idx_map [mbrr_pkg::BYTE_VALUES];
    logic [7:0]             r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_valid;
    logic [7:0]             r_rdata;
    logic                   r_rvalid;
    logic [IW-1:0]          widx;
    logic [IW-1:0]          ridx;

    // byte address to entry, wrapping at the store depth
    for (genvar g = 0; g < mbrr_pkg::BYTE_VALUES; g++) begin : g_map
        assign idx_map[g] = IW'(g % STORE_DEPTH);
    end

    assign widx = idx_map[i_wr.addr];
    assign ridx = idx_map[i_rd.addr];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[widx] <= i_wr.data;
        end
        if (i_rd.re) begin
            r_rdata <= r_mem[ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_valid[widx] <= 1'b1;
            end
            if (i_rd.re) begin
                r_rvalid <= r_valid[ridx];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : 8'h00;

endmodule

// ----- rtl/mbrr_rx_ctrl.sv -----
module mbrr_rx_ctrl #(
    parameter int MAX_FRAME = mbrr_pkg::MAX_FRAME_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  mbrr_pkg::t_op        i_operation,
    input  logic [7:0]           i_data_byte,
    input  logic [7:0]           i_store_address,
    input  logic [7:0]           i_slave_address,
    input  logic [7:0]           i_idle_ticks,
    output mbrr_pkg::t_store_wr  o_wr,
    output mbrr_pkg::t_store_rd  o_rd,
    output logic                 o_item_valid,
    output mbrr_pkg::t_tx_item   o_item
);

    localparam int FLW       = $clog2(MAX_FRAME + 2);
    localparam int HDR_LEN   = 6;
    localparam int HW        = $clog2(HDR_LEN);
    localparam int MIN_FRAME = 8;
    localparam int HDR_ADDR  = 0;
    localparam int HDR_FUNC  = 1;
    localparam int HDR_START = 3;
    localparam int HDR_QTY   = 5;
    localparam int BODY_OFS  = 3;

    logic [FLW-1:0]             r_frame_length, n_frame_length;
    logic [7:0]                 r_idle_count, n_idle_count;
    logic [15:0]                r_rx_crc, n_rx_crc;
    logic [7:0]                 r_header [HDR_LEN];
    logic [7:0]                 n_header [HDR_LEN];
    logic                       r_pending, n_pending;
    logic [mbrr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 r_start, n_start;
    logic [7:0]                 r_count, n_count;

    logic [7:0]                 idle_inc;
    logic [mbrr_pkg::POS_W-1:0] body_end;
    mbrr_pkg::t_status          status;
    mbrr_pkg::t_sel             sel;

    assign body_end = {1'b0, r_count} + mbrr_pkg::POS_W'(BODY_OFS);
    assign idle_inc = (r_idle_count == 8'hFF) ? r_idle_count : r_idle_count + 8'd1;

    always_comb begin
        if (r_frame_length < FLW'(MIN_FRAME) || r_frame_length > FLW'(MAX_FRAME)) begin
            status = mbrr_pkg::ST_LEN;
        end else if (r_rx_crc != 16'h0000) begin
            status = mbrr_pkg::ST_CRC;
        end else if (r_header[HDR_ADDR] != i_slave_address) begin
            status = mbrr_pkg::ST_ADDR;
        end else if (r_header[HDR_FUNC] != mbrr_pkg::FUNC_READ_HOLDING) begin
            status = mbrr_pkg::ST_FUNC;
        end else begin
            status = mbrr_pkg::ST_OK;
        end
    end

    always_comb begin
        if (r_pos == mbrr_pkg::POS_W'(0)) begin
            sel = mbrr_pkg::SEL_ADDR;
        end else if (r_pos == mbrr_pkg::POS_W'(1)) begin
            sel = mbrr_pkg::SEL_FUNC;
        end else if (r_pos == mbrr_pkg::POS_W'(2)) begin
            sel = mbrr_pkg::SEL_COUNT;
        end else if (r_pos < body_end) begin
            sel = mbrr_pkg::SEL_BODY;
        end else if (r_pos == body_end) begin
            sel = mbrr_pkg::SEL_CRC_LO;
        end else begin
            sel = mbrr_pkg::SEL_CRC_HI;
        end
    end

    always_comb begin
        n_frame_length = r_frame_length;
        n_idle_count   = r_idle_count;
        n_rx_crc       = r_rx_crc;
        n_header       = r_header;
        n_pending      = r_pending;
        n_pos          = r_pos;
        n_start        = r_start;
        n_count        = r_count;
        o_wr           = '0;
        o_rd           = '0;
        o_item_valid   = 1'b0;
        o_item         = '0;
        if (i_accept) begin
            unique case (i_operation)
                mbrr_pkg::OP_RX_BYTE: begin
                    if (r_frame_length < FLW'(MAX_FRAME)) begin
                        if (r_frame_length < FLW'(HDR_LEN)) begin
                            n_header[r_frame_length[HW-1:0]] = i_data_byte;
                        end
                        n_rx_crc       = mbrr_pkg::crc_byte(r_rx_crc, i_data_byte);
                        n_frame_length = r_frame_length + FLW'(1);
                    end else begin
                        n_frame_length = FLW'(MAX_FRAME + 1);
                    end
                    n_idle_count = 8'h00;
                end
                mbrr_pkg::OP_TICK: begin
                    if (r_frame_length != '0) begin
                        if (idle_inc < i_idle_ticks) begin
                            n_idle_count = idle_inc;
                        end else begin
                            if (status == mbrr_pkg::ST_OK) begin
                                n_pending       = 1'b1;
                                n_pos           = '0;
                                n_start         = r_header[HDR_START];
                                n_count         = {r_header[HDR_QTY][6:0], 1'b0};
                                o_item.crc_init = 1'b1;
                            end
                            n_frame_length = '0;
                            n_idle_count   = 8'h00;
                            n_rx_crc       = mbrr_pkg::CRC_INIT;
                            for (int i = 0; i < HDR_LEN; i++) begin
                                n_header[i] = 8'h00;
                            end
                            o_item_valid     = 1'b1;
                            o_item.is_report = 1'b1;
                            o_item.status    = status;
                        end
                    end
                end
                mbrr_pkg::OP_STORE_WR: begin
                    o_wr.we   = 1'b1;
                    o_wr.addr = i_store_address;
                    o_wr.data = i_data_byte;
                end
                mbrr_pkg::OP_TX_PULL: begin
                    if (r_pending) begin
                        o_item_valid = 1'b1;
                        o_item.sel   = sel;
                        o_item.count = r_count;
                        o_rd.re      = (sel == mbrr_pkg::SEL_BODY);
                        o_rd.addr    = r_start + r_pos[7:0] - 8'(BODY_OFS);
                        if (sel == mbrr_pkg::SEL_CRC_HI) begin
                            o_item.last = 1'b1;
                            n_pending   = 1'b0;
                            n_pos       = '0;
                        end else begin
                            n_pos = r_pos + mbrr_pkg::POS_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= '0;
            r_idle_count   <= 8'h00;
            r_rx_crc       <= mbrr_pkg::CRC_INIT;
            for (int i = 0; i < HDR_LEN; i++) begin
                r_header[i] <= 8'h00;
            end
            r_pending <= 1'b0;
            r_pos     <= '0;
            r_start   <= 8'h00;
            r_count   <= 8'h00;
        end else begin
            r_frame_length <= n_frame_length;
            r_idle_count   <= n_idle_count;
            r_rx_crc       <= n_rx_crc;
            r_header       <= n_header;
            r_pending      <= n_pending;
            r_pos          <= n_pos;
            r_start        <= n_start;
            r_count        <= n_count;
        end
    end

endmodule

// ----- rtl/mbrr_reply_tx.sv -----
module mbrr_reply_tx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  mbrr_pkg::t_tx_item i_item,
    input  logic [7:0]         i_rdata,
    input  logic [7:0]         i_slave_address,
    output logic               o_slot_free,
    mbrr_out_if.source         o_rsp
);

    logic               r_s1_valid;
    mbrr_pkg::t_tx_item r_s1;
    logic               r_out_valid;
    logic               r_kind;
    logic [7:0]         r_tx_byte;
    logic               r_last;
    logic [2:0]         r_status;
    logic [15:0]        r_tx_crc, n_tx_crc;
    logic               s1_adv;
    logic [7:0]         byte_sel;

    assign s1_adv      = !r_out_valid || o_rsp.ready;
    assign o_slot_free = !r_s1_valid || s1_adv;

    always_comb begin
        unique case (r_s1.sel)
            mbrr_pkg::SEL_ADDR:   byte_sel = i_slave_address;
            mbrr_pkg::SEL_FUNC:   byte_sel = mbrr_pkg::FUNC_READ_HOLDING;
            mbrr_pkg::SEL_COUNT:  byte_sel = r_s1.count;
            mbrr_pkg::SEL_BODY:   byte_sel = i_rdata;
            mbrr_pkg::SEL_CRC_LO: byte_sel = r_tx_crc[7:0];
            mbrr_pkg::SEL_CRC_HI: byte_sel = r_tx_crc[15:8];
            default:              byte_sel = 8'h00;
        endcase
    end

    // crc runs over the header and body bytes only
    always_comb begin
        n_tx_crc = r_tx_crc;
        if (r_s1_valid && s1_adv) begin
            if (r_s1.is_report) begin
                if (r_s1.crc_init) begin
                    n_tx_crc = mbrr_pkg::CRC_INIT;
                end
            end else if (r_s1.sel != mbrr_pkg::SEL_CRC_LO && r_s1.sel != mbrr_pkg::SEL_CRC_HI) begin
                n_tx_crc = mbrr_pkg::crc_byte(r_tx_crc, byte_sel);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tx_crc    <= mbrr_pkg::CRC_INIT;
        end else begin
            if (o_slot_free) begin
                r_s1_valid <= i_item_valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            r_tx_crc <= n_tx_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_slot_free && i_item_valid) begin
            r_s1 <= i_item;
        end
        if (r_s1_valid && s1_adv) begin
            r_kind    <= r_s1.is_report;
            r_tx_byte <= r_s1.is_report ? 8'h00 : byte_sel;
            r_last    <= r_s1.is_report ? 1'b0 : r_s1.last;
            r_status  <= r_s1.is_report ? r_s1.status : mbrr_pkg::ST_OK;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.kind         = r_kind;
    assign o_rsp.tx_byte      = r_tx_byte;
    assign o_rsp.last_byte    = r_last;
    assign o_rsp.frame_status = r_status;

endmodule

// ----- rtl/modbus_rtu_read_register_responder.sv -----
// channel   dir  signals                                        request
// i_req     in   valid ready operation data_byte store_address  rx byte, tick, store write, pull
// o_rsp     out  valid ready kind tx_byte last_byte frame_status reply byte or frame outcome
// apb       in   psel penable pwrite paddr pwdata prdata pready   slave_address @0, idle_ticks @4
//
// one request per cycle while i_req.ready is high; a request and its register store read are
// registered in the byte stage, then byte select and reply crc update feed the output register
// reset: one cycle, store entries read as zero until written (per-entry valid bits)
// i_req.ready drops only while the output register holds an untaken result and the
// byte stage behind it is also full

module modbus_rtu_read_register_responder #(
    parameter int STORE_DEPTH = mbrr_pkg::STORE_DEPTH_DEF,
    parameter int MAX_FRAME   = mbrr_pkg::MAX_FRAME_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mbrr_in_if.sink                     i_req,
    mbrr_out_if.source                  o_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbrr_pkg::APB_AW-1:0] paddr,
    input  logic [mbrr_pkg::APB_DW-1:0] pwdata,
    output logic [mbrr_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    logic [7:0]          slave_address;
    logic [7:0]          idle_ticks;
    logic                slot_free;
    logic                accept;
    mbrr_pkg::t_store_wr store_wr;
    mbrr_pkg::t_store_rd store_rd;
    logic [7:0]          rdata;
    logic                item_valid;
    mbrr_pkg::t_tx_item  item;

    assign i_req.ready = slot_free;
    assign accept      = i_req.valid && slot_free;

    mbrr_apb_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_slave_address (slave_address),
        .o_idle_ticks    (idle_ticks)
    );

    mbrr_rx_ctrl #(
        .MAX_FRAME (MAX_FRAME)
    ) u_rx (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_operation     (mbrr_pkg::t_op'(i_req.operation)),
        .i_data_byte     (i_req.data_byte),
        .i_store_address (i_req.store_address),
        .i_slave_address (slave_address),
        .i_idle_ticks    (idle_ticks),
        .o_wr            (store_wr),
        .o_rd            (store_rd),
        .o_item_valid    (item_valid),
        .o_item          (item)
    );

    mbrr_reg_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (store_wr),
        .i_rd    (store_rd),
        .o_rdata (rdata)
    );

    mbrr_reply_tx u_tx (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (item_valid),
        .i_item          (item),
        .i_rdata         (rdata),
        .i_slave_address (slave_address),
        .o_slot_free     (slot_free),
        .o_rsp           (o_rsp)
    );

endmodule

// ----- tb/mbrr_checker.sv -----
`timescale 1ns / 100ps

module mbrr_checker
    import mbrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbrr_in_if                i_req,
    mbrr_out_if               i_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                o_errors,
    output int                o_pending
);

    localparam int STORE_DEPTH = STORE_DEPTH_DEF;
    localparam int MAX_FRAME   = MAX_FRAME_DEF;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last_byte;
        t_status    status;
    } t_rsp_item;

    logic [7:0]  station_cfg;
    logic [7:0]  idle_cfg;

    logic [8:0]  rx_len;
    logic [7:0]  rx_idle;
    logic [15:0] rx_crc;
    logic [7:0]  rx_hdr [6];
    logic [7:0]  regs [STORE_DEPTH];

    logic        reply_busy;
    logic [8:0]  reply_pos;
    logic [7:0]  reply_base;
    logic [7:0]  reply_len;
    logic [15:0] reply_crc;

    t_rsp_item   rsp_due [$];

    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    task automatic predict_request(t_op op, logic [7:0] data, logic [7:0] saddr);
        t_status    verdict;
        logic [8:0] body_end;
        logic [7:0] b;
        logic [7:0] slot;
        logic       last_b;
        case (op)
            OP_RX_BYTE: begin
                if (rx_len < MAX_FRAME) begin
                    if (rx_len < 6) begin
                        rx_hdr[rx_len[2:0]] = data;
                    end
                    rx_crc = crc16_next(rx_crc, data);
                    rx_len = rx_len + 9'd1;
                end else begin
                    rx_len = 9'(MAX_FRAME + 1);
                end
                rx_idle = 8'd0;
            end
            OP_TICK: begin
                if (rx_len != 0) begin
                    if (rx_idle != 8'hFF) begin
                        rx_idle = rx_idle + 8'd1;
                    end
                    if (rx_idle >= idle_cfg) begin
                        if (rx_len < 8 || rx_len > MAX_FRAME) begin
                            verdict = ST_LEN;
                        end else if (rx_crc != 16'h0000) begin
                            verdict = ST_CRC;
                        end else if (rx_hdr[0] != station_cfg) begin
                            verdict = ST_ADDR;
                        end else if (rx_hdr[1] != FUNC_READ_HOLDING) begin
                            verdict = ST_FUNC;
                        end else begin
                            verdict = ST_OK;
                        end
                        if (verdict == ST_OK) begin
                            reply_busy = 1'b1;
                            reply_pos  = 9'd0;
                            reply_base = rx_hdr[3];
                            reply_len  = {rx_hdr[5][6:0], 1'b0};
                            reply_crc  = 16'hFFFF;
                        end
                        rx_len  = 9'd0;
                        rx_idle = 8'd0;
                        rx_crc  = 16'hFFFF;
                        foreach (rx_hdr[i]) rx_hdr[i] = 8'd0;
                        rsp_due.push_back('{kind: 1'b1, tx_byte: 8'h00, last_byte: 1'b0,
                                            status: verdict});
                    end
                end
            end
            OP_STORE_WR: begin
                regs[IDX_W'(saddr % STORE_DEPTH)] = data;
            end
            OP_TX_PULL: begin
                if (reply_busy) begin
                    body_end = {1'b0, reply_len} + 9'd3;
                    last_b   = 1'b0;
                    if (reply_pos == 0) begin
                        b = station_cfg;
                    end else if (reply_pos == 1) begin
                        b = FUNC_READ_HOLDING;
                    end else if (reply_pos == 2) begin
                        b = reply_len;
                    end else if (reply_pos < body_end) begin
                        slot = reply_base + reply_pos[7:0] - 8'd3;
                        b = regs[IDX_W'(slot % STORE_DEPTH)];
                    end else if (reply_pos == body_end) begin
                        b = reply_crc[7:0];
                    end else begin
                        b = reply_crc[15:8];
                        last_b = 1'b1;
                    end
                    if (reply_pos < body_end) begin
                        reply_crc = crc16_next(reply_crc, b);
                    end
                    if (last_b) begin
                        reply_busy = 1'b0;
                        reply_pos  = 9'd0;
                    end else begin
                        reply_pos = reply_pos + 9'd1;
                    end
                    rsp_due.push_back('{kind: 1'b0, tx_byte: b, last_byte: last_b,
                                        status: ST_OK});
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_rsp_item want;
        if (!i_rst_n) begin
            station_cfg = 8'd1;
            idle_cfg    = 8'd3;
            rx_len      = 9'd0;
            rx_idle     = 8'd0;
            rx_crc      = 16'hFFFF;
            foreach (rx_hdr[i]) rx_hdr[i] = 8'd0;
            foreach (regs[i]) regs[i] = 8'd0;
            reply_busy  = 1'b0;
            reply_pos   = 9'd0;
            reply_base  = 8'd0;
            reply_len   = 8'd0;
            reply_crc   = 16'hFFFF;
            rsp_due.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_due.size() == 0) begin
                    o_errors++;
                    $error("result with none expected: kind %0d tx_byte 0x%02h status %0d",
                           i_rsp.kind, i_rsp.tx_byte, i_rsp.frame_status);
                end else begin
                    want = rsp_due.pop_front();
                    if (i_rsp.kind !== want.kind) begin
                        o_errors++;
                        $error("kind: expected %0d, got %0d", want.kind, i_rsp.kind);
                    end
                    if (i_rsp.tx_byte !== want.tx_byte) begin
                        o_errors++;
                        $error("tx_byte: expected 0x%02h, got 0x%02h",
                               want.tx_byte, i_rsp.tx_byte);
                    end
                    if (i_rsp.last_byte !== want.last_byte) begin
                        o_errors++;
                        $error("last_byte: expected %0d, got %0d",
                               want.last_byte, i_rsp.last_byte);
                    end
                    if (i_rsp.frame_status !== want.status) begin
                        o_errors++;
                        $error("frame_status: expected %0d, got %0d",
                               want.status, i_rsp.frame_status);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_request(t_op'(i_req.operation), i_req.data_byte, i_req.store_address);
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_SLAVE_ADDRESS: station_cfg = pwdata[7:0];
                    REG_IDLE_TICKS:    idle_cfg = pwdata[7:0];
                endcase
            end
        end
        o_pending = rsp_due.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import mbrr_pkg::*;

    localparam int REQUEST_TARGET = 1950;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int N_PHASES       = 6;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic              pready;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;

    int         err_count;
    int         due_count;
    int         sent_count;
    int         cycle_count;
    logic [7:0] station_now;
    logic [7:0] idle_now;
    bit         steady_tx;

    mbrr_in_if  req_if ();
    mbrr_out_if rsp_if ();

    modbus_rtu_read_register_responder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mbrr_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .i_rsp     (rsp_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .o_errors  (err_count),
        .o_pending (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // reply sink with random backpressure
    initial begin
        int on_cycles;
        int off_cycles;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            on_cycles  = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 8);
            off_cycles = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                      : $urandom_range(1, 3);
            rsp_if.ready <= 1'b1;
            repeat (on_cycles) @(posedge i_clk);
            rsp_if.ready <= 1'b0;
            repeat (off_cycles) @(posedge i_clk);
        end
    end

    function automatic int end_ticks();
        return (idle_now == 0) ? 1 : int'(idle_now);
    endfunction

    function automatic int reply_bytes(logic [7:0] qty_lo);
        return int'({qty_lo[6:0], 1'b0}) + 5;
    endfunction

    function automatic logic [7:0] pick_qty();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    endfunction

    task automatic send_request(t_op op, logic [7:0] data, logic [7:0] saddr);
        int gap;
        int r;
        req_if.valid         <= 1'b1;
        req_if.operation     <= op;
        req_if.data_byte     <= data;
        req_if.store_address <= saddr;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sent_count++;
        r = $urandom_range(0, 99);
        if (steady_tx || r < 60) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else if (r < 98) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_request(OP_TICK, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_frame(logic [7:0] station, logic [7:0] func, logic [7:0] start_lo,
                              logic [7:0] qty_lo, int extra, bit corrupt, int keep);
        logic [7:0]  fb [$];
        logic [15:0] crc;
        int          pos;
        fb = '{station, func, 8'($urandom), start_lo, 8'($urandom), qty_lo};
        repeat (extra) fb.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (fb[i]) crc = crc_byte(crc, fb[i]);
        fb.push_back(crc[7:0]);
        fb.push_back(crc[15:8]);
        if (corrupt) begin
            pos = $urandom_range(0, fb.size() - 1);
            fb[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
        if (keep > 0 && keep < fb.size()) begin
            fb = fb[0:keep-1];
        end
        foreach (fb[i]) begin
            send_request(OP_RX_BYTE, fb[i], 8'($urandom));
            // gaps shorter than the idle threshold keep the frame open
            if (idle_now >= 2 && i + 1 < fb.size() && $urandom_range(0, 9) == 0) begin
                send_ticks($urandom_range(1, (idle_now > 4) ? 3 : idle_now - 1));
            end
        end
        send_ticks(end_ticks());
    endtask

    task automatic pull_reply(int n);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request(OP_STORE_WR, 8'($urandom), 8'($urandom));
            end
            send_request(OP_TX_PULL, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic good_request(output int len);
        logic [7:0] qty;
        qty = pick_qty();
        send_frame(station_now, FUNC_READ_HOLDING, 8'($urandom), qty,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0, 1'b0, 0);
        len = reply_bytes(qty);
    endtask

    task automatic run_scenario();
        int         r;
        int         k;
        int         len;
        logic [7:0] qty;
        logic [7:0] other;
        r = $urandom_range(0, 99);
        steady_tx = ($urandom_range(0, 4) == 0);
        if (r < 45) begin
            good_request(len);
            pull_reply(($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : len);
        end else if (r < 55) begin
            // second request overtakes a reply in progress
            good_request(len);
            pull_reply($urandom_range(1, len - 1));
            good_request(len);
            pull_reply(len);
        end else if (r < 72) begin
            k = $urandom_range(0, 3);
            if (k == 0) begin
                other = station_now + 8'($urandom_range(1, 255));
                send_frame(other, FUNC_READ_HOLDING, 8'($urandom), pick_qty(), 0, 1'b0, 0);
            end else if (k == 1) begin
                other = 8'($urandom_range(0, 254));
                if (other >= FUNC_READ_HOLDING) begin
                    other = other + 8'd1;
                end
                send_frame(station_now, other, 8'($urandom), pick_qty(), 0, 1'b0, 0);
            end else if (k == 2) begin
                send_frame(station_now, FUNC_READ_HOLDING, 8'($urandom), pick_qty(), 0, 1'b1, 0);
            end else begin
                send_frame(station_now, FUNC_READ_HOLDING, 8'($urandom), pick_qty(), 0, 1'b0,
                           $urandom_range(1, 7));
            end
            pull_reply($urandom_range(0, 3));
        end else if (r == 72) begin
            // 255 to 260 bytes on the wire, the last ones past the frame limit
            k   = $urandom_range(247, 252);
            qty = pick_qty();
            send_frame(station_now, FUNC_READ_HOLDING, 8'($urandom), qty, k, 1'b0, 0);
            pull_reply((k + 8 <= MAX_FRAME_DEF) ? reply_bytes(qty) : 2);
        end else if (r < 87) begin
            repeat ($urandom_range(1, 8)) begin
                send_request(t_op'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            end
            send_ticks(end_ticks());
        end else begin
            repeat ($urandom_range(1, 12)) begin
                send_request(OP_STORE_WR, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_SLAVE_ADDRESS) begin
            station_now = value;
        end else begin
            idle_now = value;
        end
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (due_count != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int         p;
        logic [7:0] st;
        logic [7:0] it;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        req_if.valid         <= 1'b0;
        req_if.operation     <= OP_RX_BYTE;
        req_if.data_byte     <= 8'd0;
        req_if.store_address <= 8'd0;
        station_now = 8'd1;
        idle_now    = 8'd3;
        steady_tx   = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(OP_TX_PULL, 8'h00, 8'h00);
        send_request(OP_TICK, 8'hFF, 8'hFF);
        send_request(OP_STORE_WR, 8'hFF, 8'hFF);
        send_request(OP_STORE_WR, 8'h80, 8'h00);
        // start address 0xFF reads across the end of the store
        send_frame(8'd1, FUNC_READ_HOLDING, 8'hFF, 8'd1, 0, 1'b0, 0);
        pull_reply(reply_bytes(8'd1));

        for (p = 0; p < N_PHASES; p++) begin
            settle();
            st = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : (p == 5) ? 8'h01 : 8'($urandom);
            it = (p == 0) ? 8'd1 : (p == 1) ? 8'd2 : (p == 2) ? 8'd255 : (p == 3) ? 8'd0 :
                 (p == 4) ? 8'($urandom_range(3, 8)) : 8'd3;
            write_reg(REG_SLAVE_ADDRESS, st);
            write_reg(REG_IDLE_TICKS, it);
            while (sent_count < REQUEST_TARGET * (p + 1) / N_PHASES) run_scenario();
        end

        settle();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
